// ===== hw/rtl/tcpq_pkg.sv =====
// Package for the three-class priority queue: sizes, codes, cell control
// struct and width conversion helpers. No dependencies.
package tcpq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int HANDLE_WIDTH = 16;
   localparam int IDX_WIDTH    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Port field widths are fixed by the interface.
   localparam int PORT_HANDLE_WIDTH = 16;
   localparam int PORT_COUNT_WIDTH  = 5;
   localparam int KEY_WIDTH         = 8;
   localparam int STATUS_WIDTH      = 2;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   localparam logic CSR_HIGH_THRESHOLD = 1'b0;
   localparam logic CSR_LOW_THRESHOLD  = 1'b1;

   localparam logic [KEY_WIDTH-1:0] HIGH_THRESHOLD_RESET = 8'd80;
   localparam logic [KEY_WIDTH-1:0] LOW_THRESHOLD_RESET  = 8'd10;

   typedef logic [HANDLE_WIDTH-1:0] handle_type;
   typedef logic [KEY_WIDTH-1:0]    key_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [IDX_WIDTH-1:0]    idx_type;

   // What every cell does in a cycle.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_HEAD,
      OP_LOW,
      OP_TAIL,
      OP_POP
   } cell_op_type;

   // Control broadcast from the top level to the row of cells.
   typedef struct packed {
      cell_op_type op;
      handle_type  handle;
      key_type     key;
      count_type   count;
      key_type     high_threshold;
   } cell_ctrl_type;

   // Port handle to stored handle: truncate or zero extend.
   function automatic handle_type handle_from_port(input logic [PORT_HANDLE_WIDTH-1:0] value);
      handle_type result;
      result = '0;
      for (int b = 0; b < HANDLE_WIDTH; b++) begin
         if (b < PORT_HANDLE_WIDTH) result[b] = value[b];
      end
      return result;
   endfunction

   // Stored handle to port handle: truncate or zero extend.
   function automatic logic [PORT_HANDLE_WIDTH-1:0] handle_to_port(input handle_type value);
      logic [PORT_HANDLE_WIDTH-1:0] result;
      result = '0;
      for (int b = 0; b < PORT_HANDLE_WIDTH; b++) begin
         if (b < HANDLE_WIDTH) result[b] = value[b];
      end
      return result;
   endfunction

   // Internal count to the port count field.
   function automatic logic [PORT_COUNT_WIDTH-1:0] count_to_port(input count_type value);
      logic [PORT_COUNT_WIDTH-1:0] result;
      result = '0;
      for (int b = 0; b < PORT_COUNT_WIDTH; b++) begin
         if (b < COUNT_WIDTH) result[b] = value[b];
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/three_class_priority_queue.sv =====
// Three-class priority queue built as a row of shifting slots.
// The result is registered: it appears in the cycle after the request transfer.
// Throughput: one command per cycle; a request waits only while a result
// is held in the output register and not taken.
// Reset clears the entry count and the result valid flag, and sets the
// thresholds to 80 and 10; slot contents need no clearing pass.
module three_class_priority_queue
   import tcpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] record_handle, [23:16] priority_key
   input  logic [0:0]  req_tuser,   // [0] command
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] out_handle, [16] queue_empty,
                                    // [21:17] entry_count, [23:22] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   key_type       high_threshold_ff, high_threshold_in;
   key_type       low_threshold_ff, low_threshold_in;
   count_type     count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PORT_HANDLE_WIDTH-1:0] rsp_handle_ff, rsp_handle_in;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff, rsp_status_in;
   count_type     rsp_count_ff, rsp_count_in;

   cell_ctrl_type ctrl;
   logic          req_accept;
   logic          command;
   key_type       req_key;
   handle_type    req_handle;

   handle_type    cell_handle [QUEUE_DEPTH];
   key_type       cell_key    [QUEUE_DEPTH];
   logic          top_run     [QUEUE_DEPTH+1];

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign command    = req_tuser[0];
   assign req_key    = req_tdata[23:16];
   assign req_handle = handle_from_port(req_tdata[15:0]);

   // Threshold registers.
   always_comb begin
      high_threshold_in = high_threshold_ff;
      low_threshold_in  = low_threshold_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index[0])
            CSR_HIGH_THRESHOLD: high_threshold_in = csr_data;
            CSR_LOW_THRESHOLD:  low_threshold_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Command decode: pick the row operation, the new count and the result.
   always_comb begin
      ctrl.op             = OP_HOLD;
      ctrl.handle         = req_handle;
      ctrl.key            = req_key;
      ctrl.count          = count_ff;
      ctrl.high_threshold = high_threshold_ff;
      count_in            = count_ff;
      rsp_handle_in       = rsp_handle_ff;
      rsp_status_in       = rsp_status_ff;
      rsp_count_in        = rsp_count_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_tready;

      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = '0;
         rsp_status_in = STATUS_DONE;
         case (command)
            CMD_ENQUEUE: begin
               if (count_ff == count_type'(QUEUE_DEPTH)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (req_key >= high_threshold_ff) ctrl.op = OP_HEAD;
                  else if (req_key < low_threshold_ff) ctrl.op = OP_LOW;
                  else ctrl.op = OP_TAIL;
               end
            end
            CMD_DEQUEUE: begin
               if (count_ff == '0) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  count_in      = count_ff - 1'b1;
                  ctrl.op       = OP_POP;
                  rsp_handle_in = handle_to_port(cell_handle[0]);
               end
            end
            default: begin
            end
         endcase
         rsp_count_in = count_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         high_threshold_ff <= HIGH_THRESHOLD_RESET;
         low_threshold_ff  <= LOW_THRESHOLD_RESET;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         high_threshold_ff <= high_threshold_in;
         low_threshold_ff  <= low_threshold_in;
         count_ff          <= count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, count_to_port(rsp_count_ff), (rsp_count_ff == '0), rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Row of slots; slot 0 is the head.
   assign top_run[0] = 1'b1;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      handle_type prev_handle;
      key_type    prev_key;
      handle_type next_handle;
      key_type    next_key;

      if (i == 0) begin : g_first
         assign prev_handle = req_handle;
         assign prev_key    = req_key;
      end else begin : g_inner_prev
         assign prev_handle = cell_handle[i-1];
         assign prev_key    = cell_key[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_handle = '0;
         assign next_key    = '0;
      end else begin : g_inner_next
         assign next_handle = cell_handle[i+1];
         assign next_key    = cell_key[i+1];
      end

      tcpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .index       (idx_type'(i)),
         .prev_handle (prev_handle),
         .prev_key    (prev_key),
         .next_handle (next_handle),
         .next_key    (next_key),
         .top_run_in  (top_run[i]),
         .top_run_out (top_run[i+1]),
         .cell_handle (cell_handle[i]),
         .cell_key    (cell_key[i])
      );
   end

endmodule

// ===== hw/rtl/tcpq_cell.sv =====
// One slot of the queue row: holds a handle and a key, and each cycle keeps,
// loads the new entry, or takes the entry of its left or right neighbor.
// Depends on tcpq_pkg.
module tcpq_cell
   import tcpq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  idx_type       index,
   input  handle_type    prev_handle,
   input  key_type       prev_key,
   input  handle_type    next_handle,
   input  key_type       next_key,
   input  logic          top_run_in,
   output logic          top_run_out,
   output handle_type    cell_handle,
   output key_type       cell_key
);

   handle_type handle_ff, handle_in;
   key_type    key_ff, key_in;
   logic       occupied;
   logic       self_top;
   logic       at_pos;
   logic       after_pos;
   logic       take_next;

   // Top-class run: every slot so far holds a key at or above the threshold.
   always_comb begin
      occupied    = count_type'(index) < ctrl.count;
      self_top    = occupied && (key_ff >= ctrl.high_threshold);
      top_run_out = top_run_in && self_top;
   end

   // Decide whether this slot loads the new entry or shifts.
   always_comb begin
      at_pos    = 1'b0;
      after_pos = 1'b0;
      take_next = 1'b0;
      case (ctrl.op)
         OP_HEAD: begin
            at_pos    = (index == '0);
            after_pos = (index != '0);
         end
         OP_LOW: begin
            at_pos    = top_run_in && !self_top;
            after_pos = !top_run_in;
         end
         OP_TAIL: begin
            at_pos = (count_type'(index) == ctrl.count);
         end
         OP_POP: begin
            take_next = 1'b1;
         end
         default: begin
         end
      endcase

      if (at_pos) begin
         handle_in = ctrl.handle;
         key_in    = ctrl.key;
      end else if (after_pos) begin
         handle_in = prev_handle;
         key_in    = prev_key;
      end else if (take_next) begin
         handle_in = next_handle;
         key_in    = next_key;
      end else begin
         handle_in = handle_ff;
         key_in    = key_ff;
      end
   end

   // Slot contents carry no reset; only slots below the count are read.
   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      key_ff    <= key_in;
   end

   assign cell_handle = handle_ff;
   assign cell_key    = key_ff;

endmodule
